### sv/rcvs_pkg.sv
// ---------------------------------------------------------------------------
// rcvs_pkg
// Shared constants and controller/datapath interface types for the
// raised cosine variate sampler.
// ---------------------------------------------------------------------------
package rcvs_pkg;

  localparam int MAX_TERM_PAIRS_DEF = 16;
  localparam int FRACTION_BITS_DEF  = 30;

  // pi in signed Q3.29
  localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;

  // multiplier operand selection
  localparam logic [1:0] OP_SQ = 2'd0;  // |x| * |x|
  localparam logic [1:0] OP_VX = 2'd1;  // term * x^2
  localparam logic [1:0] OP_VR = 2'd2;  // term * reciprocal

  typedef struct packed {
    logic       init;       // capture input transfer, reset series state
    logic [1:0] mul_op;     // operand pair
    logic       mul_issue;  // issue one 32x32 partial product
    logic [1:0] mul_sel;    // which halves: {a_hi, b_hi}
    logic       acc_clr;    // clear product accumulator
    logic       acc_add;    // add registered partial product
    logic       ld_xsq;     // x^2 from accumulator
    logic       ld_v;       // term from accumulator, shifted by F
    logic       upd_step;   // finish term, update sum, test
    logic       ld_out;     // copy result into output register
  } cmd_t;

  typedef struct packed {
    logic decided;    // current step hits a bound
    logic last_step;  // current step is the final one
  } sts_t;

endpackage

### sv/raised_cosine_variate_sampler.sv
// ---------------------------------------------------------------------------
// raised_cosine_variate_sampler
// Raised cosine variate by alternating-series rejection, fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: one transfer per sample, tdata = {unit_fraction, angle}.
//   angle is signed Q2.30 over -pi/2..pi/2, unit_fraction unsigned 0.32.
//   Output stream: one transfer per input, tdata = variate (signed Q3.29),
//   tuser[0] = gave_up (variate then zero).
//   Timing: out_tvalid rises after the square of the angle, the series
//   terms and the output load; n = number of series terms evaluated
//   (1 .. 2*MAX_TERM_PAIRS, usually one to three). Each term costs two
//   64x64 products, each four 32x32 partial products through the single
//   shared multiplier, plus a load step and an update/test step.
//   One item at a time: in_tready is high only while the sequencer is
//   idle, so no new input is taken before the last one is finished.
//   The output register decouples the sides: a new input is taken while
//   a result still waits; a second finished result waits in the sequencer
//   until the receiver takes the first.
//   Reset (rst_n low, synchronous) empties the output register and
//   returns the sequencer to idle; no memory to clear.
// ---------------------------------------------------------------------------
module raised_cosine_variate_sampler #(
  parameter int MAX_TERM_PAIRS = rcvs_pkg::MAX_TERM_PAIRS_DEF,
  parameter int FRACTION_BITS  = rcvs_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] angle_sample, [63:32] unit_fraction
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] variate_value
  output logic [0:0]  out_tuser   // [0] gave_up
);

  rcvs_pkg::cmd_t cmd;
  rcvs_pkg::sts_t sts;
  logic           gave_up;

  // sequencer: state, partial product counter, output valid
  rcvs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // arithmetic: multiplier, accumulator, term, partial sum, result
  rcvs_dp #(
    .MAX_TERM_PAIRS (MAX_TERM_PAIRS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .angle_sample  (in_tdata[31:0]),
    .unit_fraction (in_tdata[63:32]),
    .sts           (sts),
    .variate_value (out_tdata),
    .gave_up       (gave_up)
  );

  assign out_tuser = gave_up;

endmodule

### sv/rcvs_ctrl.sv
// ---------------------------------------------------------------------------
// rcvs_ctrl
// Sequencer: square, then per term two 64x64 products on the shared
// 32x32 multiplier, update and test; owns the handshakes.
// ---------------------------------------------------------------------------
module rcvs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  rcvs_pkg::sts_t sts,
  output rcvs_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_LDSQ = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_LDV  = 3'd4;
  localparam logic [2:0] S_MUL2 = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  localparam logic [2:0] CNT_LAST = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       oval_r, oval_nxt;
  logic       mul_state;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;
  assign mul_state  = (state_r == S_SQ) || (state_r == S_MUL1) || (state_r == S_MUL2);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    oval_nxt  = oval_r && !out_tready;
    cmd       = '0;
    cmd.mul_op = rcvs_pkg::OP_VX;

    if (mul_state) begin
      cmd.mul_issue = (cnt_r != CNT_LAST);
      cmd.mul_sel   = cnt_r[1:0];
      cmd.acc_clr   = (cnt_r == 3'd0);
      cmd.acc_add   = (cnt_r != 3'd0);
      cnt_nxt       = (cnt_r == CNT_LAST) ? 3'd0 : cnt_r + 3'd1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.init  = 1'b1;
          cnt_nxt   = 3'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_op = rcvs_pkg::OP_SQ;
        if (cnt_r == CNT_LAST) state_nxt = S_LDSQ;
      end
      S_LDSQ: begin
        cmd.ld_xsq = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_op = rcvs_pkg::OP_VX;
        if (cnt_r == CNT_LAST) state_nxt = S_LDV;
      end
      S_LDV: begin
        cmd.ld_v  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_op = rcvs_pkg::OP_VR;
        if (cnt_r == CNT_LAST) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd_step = 1'b1;
        state_nxt    = (sts.decided || sts.last_step) ? S_FIN : S_MUL1;
      end
      S_FIN: begin
        if (!oval_r || out_tready) begin
          cmd.ld_out = 1'b1;
          oval_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 3'd0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

### sv/rcvs_dp.sv
// ---------------------------------------------------------------------------
// rcvs_dp
// Datapath: shared 32x32 multiplier with 128-bit accumulator, term and
// partial sum registers, reciprocal table, result and output registers.
// ---------------------------------------------------------------------------
module rcvs_dp #(
  parameter int MAX_TERM_PAIRS = rcvs_pkg::MAX_TERM_PAIRS_DEF,
  parameter int FRACTION_BITS  = rcvs_pkg::FRACTION_BITS_DEF
) (
  input  logic           clk,
  input  rcvs_pkg::cmd_t cmd,
  input  logic [31:0]    angle_sample,
  input  logic [31:0]    unit_fraction,
  output rcvs_pkg::sts_t sts,
  output logic [31:0]    variate_value,
  output logic           gave_up
);

  localparam int NSTEP = 2 * MAX_TERM_PAIRS;
  localparam int JW    = $clog2(NSTEP);
  localparam int XS    = 60 - FRACTION_BITS;   // x^2 alignment
  localparam logic [JW-1:0] J_LAST = JW'(NSTEP - 1);

  // reciprocals floor(2^63 / (a*b)), (a,b) = (2,1), (4,3), ...
  logic [63:0] recip_tab [NSTEP];
  for (genvar g = 0; g < NSTEP; g++) begin : g_recip
    localparam logic [63:0] DEN = 64'((2 * g + 2) * (2 * g + 1));
    localparam logic [63:0] RV  = 64'h8000_0000_0000_0000 / DEN;
    assign recip_tab[g] = RV;
  end

  logic signed [31:0] x_r;
  logic [63:0]        xsq_r;
  logic signed [63:0] tgt_r;
  logic [63:0]        v_r;
  logic signed [63:0] w_r;
  logic [JW-1:0]      j_r;
  logic [127:0]       acc_r;
  logic [63:0]        pp_r;
  logic [1:0]         pp_sh_r;
  logic signed [31:0] res_r;
  logic               gave_r;
  logic [31:0]        oval_r;
  logic               ogave_r;

  logic [31:0]  ax;
  logic [63:0]  tgt_init;
  logic [63:0]  op_a, op_b;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic [127:0] pp_ext;
  logic [63:0]  v_new;
  logic signed [63:0] w_new;
  logic         hit;
  logic signed [31:0] x29;
  logic signed [31:0] res_hit;

  assign ax = x_r[31] ? 32'(-x_r) : x_r;

  if (FRACTION_BITS >= 31) begin : g_tgt_up
    assign tgt_init = {32'b0, unit_fraction} << (FRACTION_BITS - 31);
  end else begin : g_tgt_dn
    assign tgt_init = {32'b0, unit_fraction} >> (31 - FRACTION_BITS);
  end

  always_comb begin
    unique case (cmd.mul_op)
      rcvs_pkg::OP_SQ: begin
        op_a = {32'b0, ax};
        op_b = {32'b0, ax};
      end
      rcvs_pkg::OP_VR: begin
        op_a = v_r;
        op_b = recip_tab[j_r];
      end
      default: begin
        op_a = v_r;
        op_b = xsq_r;
      end
    endcase
  end

  assign mul_a = cmd.mul_sel[1] ? op_a[63:32] : op_a[31:0];
  assign mul_b = cmd.mul_sel[0] ? op_b[63:32] : op_b[31:0];
  assign prod  = {32'b0, mul_a} * {32'b0, mul_b};

  always_comb begin
    case (pp_sh_r)
      2'd1:    pp_ext = {32'b0, pp_r, 32'b0};
      2'd2:    pp_ext = {pp_r, 64'b0};
      default: pp_ext = {64'b0, pp_r};
    endcase
  end

  // term update and alternating test
  assign v_new = acc_r[126:63];
  assign w_new = j_r[0] ? (w_r - $signed(v_new)) : (w_r + $signed(v_new));
  assign hit   = j_r[0] ? (tgt_r <= w_new) : (tgt_r >= w_new);

  assign sts.decided   = hit;
  assign sts.last_step = (j_r == J_LAST);

  assign x29 = x_r >>> 1;
  always_comb begin
    if (!j_r[0])
      res_hit = x29;
    else if (x_r == 32'sd0)
      res_hit = 32'sd0;
    else if (!x_r[31])
      res_hit = rcvs_pkg::PI_Q29 - x29;
    else
      res_hit = -rcvs_pkg::PI_Q29 - x29;
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      x_r   <= angle_sample;
      tgt_r <= tgt_init;
      v_r   <= 64'(1) << FRACTION_BITS;
      w_r   <= 64'sd0;
      j_r   <= '0;
    end
    if (cmd.mul_issue) begin
      pp_r    <= prod;
      pp_sh_r <= {1'b0, cmd.mul_sel[1]} + {1'b0, cmd.mul_sel[0]};
    end
    if (cmd.acc_clr)
      acc_r <= '0;
    else if (cmd.acc_add)
      acc_r <= acc_r + pp_ext;
    if (cmd.ld_xsq)
      xsq_r <= acc_r[63+XS:XS];
    if (cmd.ld_v)
      v_r <= acc_r[FRACTION_BITS+63:FRACTION_BITS];
    if (cmd.upd_step) begin
      v_r    <= v_new;
      w_r    <= w_new;
      j_r    <= j_r + JW'(1);
      res_r  <= hit ? res_hit : 32'sd0;
      gave_r <= !hit;
    end
    if (cmd.ld_out) begin
      oval_r  <= res_r;
      ogave_r <= gave_r;
    end
  end

  assign variate_value = oval_r;
  assign gave_up       = ogave_r;

endmodule

### sv/rcvs_checker.sv
// ---------------------------------------------------------------------------
// rcvs_checker
// Port-level assertions for the raised cosine variate sampler.
// ---------------------------------------------------------------------------
module rcvs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a give-up result carries a zero variate
  a_gave_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 32'd0)
    else $error("gave_up with nonzero variate");

  // one item at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // no result can appear within the minimum latency of an input
  a_min_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 !out_tvalid)
    else $error("result too early");

  // output register empty after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid after reset");

endmodule

bind raised_cosine_variate_sampler rcvs_checker u_rcvs_checker (.*);
